FILE: design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bpa_pkg.sv
// Types and constants of the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int PAGE_W = 12;
  localparam int ORD_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [2:0] FLAG_HEAD = 3'b001;
  localparam logic [2:0] FLAG_FREE = 3'b010;
  localparam logic [2:0] FLAG_BODY = 3'b100;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic [2:0]       flags;
  } meta_t;

  typedef struct packed {
    logic head;
    logic tail;
    logic cnt;
  } list_we_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_RM,
    S_SPLIT,
    S_MBEF,
    S_MBEFW,
    S_MAFT,
    S_MAFTW,
    S_FIN,
    S_FCHK,
    S_DONE
  } bpa_state_t;

endpackage
`default_nettype wire

FILE: design/bpa_ifs.sv
// Request and result channel interfaces.
`default_nettype none
interface bpa_req_if import bpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ORD_W-1:0]  order;
  logic [PAGE_W-1:0] page;

  modport source (output valid, operation, order, page, input ready);
  modport sink (input valid, operation, order, page, output ready);
endinterface

interface bpa_res_if import bpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] page_res;
  logic [ORD_W-1:0]  order_res;

  modport source (output valid, status, page_res, order_res, input ready);
  modport sink (input valid, status, page_res, order_res, output ready);
endinterface
`default_nettype wire

FILE: design/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/bpa_lists.sv
// Per-order free list registers: head, tail and block count.
`default_nettype none
module bpa_lists import bpa_pkg::*; #(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [$clog2(ORDERS)-1:0]    idx,
  input  wire list_we_t                     we,
  input  wire logic [$clog2(PAGES)-1:0]     head_wd,
  input  wire logic [$clog2(PAGES)-1:0]     tail_wd,
  input  wire logic [$clog2(PAGES+1)-1:0]   cnt_wd,
  output logic      [$clog2(PAGES)-1:0]     head_rd,
  output logic      [$clog2(PAGES)-1:0]     tail_rd,
  output logic      [$clog2(PAGES+1)-1:0]   cnt_rd
);

  localparam int PW    = $clog2(PAGES);
  localparam int CNW   = $clog2(PAGES+1);
  localparam int TOP   = ORDERS - 1;
  localparam int TOPSZ = 1 << TOP;
  localparam int NBLK  = PAGES >> TOP;
  localparam int LAST  = (NBLK > 0) ? (NBLK - 1) * TOPSZ : 0;

  logic [PW-1:0]  head_r [ORDERS];
  logic [PW-1:0]  tail_r [ORDERS];
  logic [CNW-1:0] cnt_r  [ORDERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDERS; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= (k == TOP) ? PW'(LAST) : '0;
        cnt_r[k]  <= (k == TOP) ? CNW'(NBLK) : '0;
      end
    end else begin
      if (we.head) head_r[idx] <= head_wd;
      if (we.tail) tail_r[idx] <= tail_wd;
      if (we.cnt)  cnt_r[idx]  <= cnt_wd;
    end
  end

  assign head_rd = head_r[idx];
  assign tail_rd = tail_r[idx];
  assign cnt_rd  = cnt_r[idx];

endmodule
`default_nettype wire

FILE: design/buddy_page_allocator.sv
// Buddy page allocator: request sequencer, page metadata and link memories.
// A bad order or an out-of-range page ends a request at once; any other unfreeable page
// fails a metadata check. An allocate skips empty orders, then splits and merges each chunk.
// A free merges level by level with free buddies; one request in flight at a time.
// The metadata memory port (one read, one write per cycle) sets the per-level cost.
// After reset a clearing pass over every page builds the top-order list; no request meanwhile.
`default_nettype none
`include "assert_macros.svh"
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 11
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bpa_req_if.sink   in_req,
  bpa_res_if.source out_res
);

  localparam int PW    = $clog2(PAGES);
  localparam int OIW   = $clog2(ORDERS);
  localparam int CNW   = $clog2(PAGES+1);
  // wide enough for a page index plus the largest block size
  localparam int SW    = PW + 6;
  localparam int TOP   = ORDERS - 1;
  localparam int TOPSZ = 1 << TOP;
  localparam int NBLK  = PAGES >> TOP;
  localparam int LIMIT = NBLK * TOPSZ;

  bpa_state_t state_r, state_nxt;

  logic [PW-1:0]     clr_r, clr_nxt;
  logic [PW-1:0]     p_r, p_nxt, q_r, q_nxt, res_p_r, res_p_nxt;
  logic [ORD_W-1:0]  o_r, o_nxt, req_r, req_nxt, si_r, si_nxt;
  logic [SW-1:0]     start_r, start_nxt;
  logic              alloc_r, alloc_nxt, rel_r, rel_nxt, before_r, before_nxt;
  logic [STAT_W-1:0] rs_status_r, rs_status_nxt;
  logic [PW-1:0]     rs_page_r, rs_page_nxt;
  logic [ORD_W-1:0]  rs_order_r, rs_order_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [ORD_W-1:0]  out_order_r, out_order_nxt;

  meta_t         meta_wdata, meta_rdata;
  logic          meta_we;
  logic [PW-1:0] meta_waddr, meta_raddr;
  logic          nx_we, pv_we;
  logic [PW-1:0] nx_waddr, nx_wdata, nx_rdata;
  logic [PW-1:0] pv_waddr, pv_wdata, pv_rdata;
  logic [PW-1:0] link_raddr;

  list_we_t       l_we;
  logic [PW-1:0]  l_head_wd, l_tail_wd, l_head, l_tail;
  logic [CNW-1:0] l_cnt_wd, l_cnt;

  logic          accept;
  logic          o_last, fh, fchk_ok, out_free;
  logic [SW-1:0] sz, p_ext;
  logic [31:0]   ci;
  logic          ci_head;

  bpa_ram #(.WIDTH($bits(meta_t)), .DEPTH(PAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  bpa_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(link_raddr), .rdata(nx_rdata)
  );

  bpa_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(link_raddr), .rdata(pv_rdata)
  );

  bpa_lists #(.PAGES(PAGES), .ORDERS(ORDERS)) u_lists (
    .clk(clk), .rst_n(rst_n), .idx(o_r[OIW-1:0]), .we(l_we),
    .head_wd(l_head_wd), .tail_wd(l_tail_wd), .cnt_wd(l_cnt_wd),
    .head_rd(l_head), .tail_rd(l_tail), .cnt_rd(l_cnt)
  );

  assign accept   = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_res.ready;

  assign sz      = SW'(1) << o_r;
  assign p_ext   = SW'(p_r);
  assign o_last  = ({1'b0, o_r} + 5'd1) >= 5'(ORDERS);
  assign fh      = (meta_rdata.order == o_r) && (meta_rdata.flags == (FLAG_HEAD | FLAG_FREE));
  assign fchk_ok = (meta_rdata.flags == FLAG_HEAD) && (meta_rdata.order < 4'(ORDERS));

  assign ci      = 32'(clr_r);
  assign ci_head = ((ci & 32'(TOPSZ - 1)) == 32'd0) && (ci < 32'(LIMIT));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == PW'(PAGES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_req.operation == OP_ALLOC) begin
            state_nxt = (in_req.order >= 4'(ORDERS)) ? S_DONE : S_SEARCH;
          end else begin
            state_nxt = (32'(in_req.page) >= 32'(PAGES)) ? S_DONE : S_FCHK;
          end
        end
      end
      S_SEARCH: begin
        if (o_r == 4'(ORDERS)) state_nxt = S_DONE;
        else if (l_cnt != '0) state_nxt = S_RM;
      end
      S_RM: state_nxt = rel_r ? S_MBEF : S_SPLIT;
      S_SPLIT: begin
        if (si_r == req_r) state_nxt = S_DONE;
        else if (start_r < SW'(PAGES)) state_nxt = S_MBEF;
      end
      S_MBEF: begin
        if (o_last) state_nxt = S_FIN;
        else if (p_ext >= sz) state_nxt = S_MBEFW;
        else state_nxt = S_MAFT;
      end
      S_MBEFW: state_nxt = fh ? S_RM : S_MAFT;
      S_MAFT: state_nxt = (p_ext + sz < SW'(PAGES)) ? S_MAFTW : S_FIN;
      S_MAFTW: state_nxt = fh ? S_RM : S_FIN;
      S_FIN: state_nxt = alloc_r ? S_SPLIT : S_DONE;
      S_FCHK: state_nxt = fchk_ok ? S_MBEF : S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt        = clr_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    res_p_nxt      = res_p_r;
    o_nxt          = o_r;
    req_nxt        = req_r;
    si_nxt         = si_r;
    start_nxt      = start_r;
    alloc_nxt      = alloc_r;
    rel_nxt        = rel_r;
    before_nxt     = before_r;
    rs_status_nxt  = rs_status_r;
    rs_page_nxt    = rs_page_r;
    rs_order_nxt   = rs_order_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_order_nxt  = out_order_r;
    meta_we        = 1'b0;
    meta_waddr     = p_r;
    meta_wdata     = '{order: 4'(ORDERS), flags: FLAG_BODY};
    meta_raddr     = q_r;
    nx_we          = 1'b0;
    nx_waddr       = pv_rdata;
    nx_wdata       = nx_rdata;
    pv_we          = 1'b0;
    pv_waddr       = nx_rdata;
    pv_wdata       = pv_rdata;
    link_raddr     = q_r;
    l_we           = '0;
    l_head_wd      = nx_rdata;
    l_tail_wd      = pv_rdata;
    l_cnt_wd       = l_cnt - CNW'(1);

    case (state_r)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = ci_head ? '{order: 4'(TOP), flags: FLAG_HEAD | FLAG_FREE}
                             : '{order: 4'(ORDERS), flags: FLAG_BODY};
        nx_we      = 1'b1;
        nx_waddr   = clr_r;
        nx_wdata   = (ci_head && (ci + 32'(TOPSZ) < 32'(LIMIT))) ? PW'(ci + 32'(TOPSZ)) : '0;
        pv_we      = 1'b1;
        pv_waddr   = clr_r;
        pv_wdata   = (ci_head && (ci >= 32'(TOPSZ))) ? PW'(ci - 32'(TOPSZ)) : '0;
        clr_nxt    = clr_r + PW'(1);
      end
      S_IDLE: begin
        meta_raddr = PW'(in_req.page);
        if (accept) begin
          alloc_nxt     = (in_req.operation == OP_ALLOC);
          rel_nxt       = (in_req.operation == OP_FREE);
          req_nxt       = in_req.order;
          o_nxt         = in_req.order;
          p_nxt         = PW'(in_req.page);
          rs_status_nxt = ST_BAD;
          rs_page_nxt   = '0;
          rs_order_nxt  = '0;
        end
      end
      S_SEARCH: begin
        if (o_r == 4'(ORDERS)) begin
          rs_status_nxt = ST_NOSPACE;
        end else if (l_cnt != '0) begin
          q_nxt      = l_head;
          link_raddr = l_head;
        end else begin
          o_nxt = o_r + 4'd1;
        end
      end
      S_RM: begin
        // unlink q from its list; link data for q arrived this cycle
        if (l_cnt == CNW'(1)) begin
          l_we.cnt = 1'b1;
          l_cnt_wd = '0;
        end else if (l_cnt != '0) begin
          l_we.cnt = 1'b1;
          if (q_r == l_head) begin
            l_we.head = 1'b1;
          end else if (q_r == l_tail) begin
            l_we.tail = 1'b1;
          end else begin
            nx_we = 1'b1;
            pv_we = 1'b1;
          end
        end
        meta_we = 1'b1;
        if (!rel_r) begin
          meta_waddr = q_r;
          meta_wdata = '{order: req_r, flags: FLAG_HEAD};
          res_p_nxt  = q_r;
          start_nxt  = SW'(q_r) + (SW'(1) << req_r);
          si_nxt     = o_r;
        end else begin
          // the absorbed block becomes body
          if (before_r) begin
            meta_waddr = p_r;
            p_nxt      = q_r;
          end else begin
            meta_waddr = q_r;
          end
          o_nxt = o_r + 4'd1;
        end
      end
      S_SPLIT: begin
        if (si_r == req_r) begin
          rs_status_nxt = ST_OK;
          rs_page_nxt   = res_p_r;
          rs_order_nxt  = req_r;
        end else begin
          si_nxt = si_r - 4'd1;
          if (start_r < SW'(PAGES)) begin
            p_nxt     = PW'(start_r);
            o_nxt     = si_r - 4'd1;
            start_nxt = start_r + (SW'(1) << (si_r - 4'd1));
            rel_nxt   = 1'b1;
          end
        end
      end
      S_MBEF: begin
        q_nxt      = PW'(p_ext - sz);
        meta_raddr = PW'(p_ext - sz);
      end
      S_MBEFW: begin
        before_nxt = 1'b1;
      end
      S_MAFT: begin
        q_nxt      = PW'(p_ext + sz);
        meta_raddr = PW'(p_ext + sz);
      end
      S_MAFTW: begin
        before_nxt = 1'b0;
      end
      S_FIN: begin
        meta_we    = 1'b1;
        meta_waddr = p_r;
        meta_wdata = '{order: o_r, flags: FLAG_HEAD | FLAG_FREE};
        l_we.tail  = 1'b1;
        l_tail_wd  = p_r;
        l_we.cnt   = 1'b1;
        l_cnt_wd   = l_cnt + CNW'(1);
        if (l_cnt == '0) begin
          l_we.head = 1'b1;
          l_head_wd = p_r;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = l_tail;
          nx_wdata = p_r;
          pv_we    = 1'b1;
          pv_waddr = p_r;
          pv_wdata = l_tail;
        end
        if (!alloc_r) begin
          rs_status_nxt = ST_OK;
          rs_page_nxt   = p_r;
          rs_order_nxt  = o_r;
        end
      end
      S_FCHK: begin
        o_nxt = meta_rdata.order;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rs_status_r;
          out_page_nxt   = PAGE_W'(rs_page_r);
          out_order_nxt  = rs_order_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      alloc_r     <= 1'b0;
      rel_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      alloc_r     <= alloc_nxt;
      rel_r       <= rel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    res_p_r      <= res_p_nxt;
    o_r          <= o_nxt;
    req_r        <= req_nxt;
    si_r         <= si_nxt;
    start_r      <= start_nxt;
    before_r     <= before_nxt;
    rs_status_r  <= rs_status_nxt;
    rs_page_r    <= rs_page_nxt;
    rs_order_r   <= rs_order_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_order_r  <= out_order_nxt;
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.status    = out_status_r;
  assign out_res.page_res  = out_page_r;
  assign out_res.order_res = out_order_r;

  `BPA_ASSERT(a_busy_after_accept, accept |=> !in_req.ready,
    "request accepted while the previous one is still in progress")
  `BPA_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE),
    "result raised outside the completion state")
  `BPA_ASSERT(a_unlink_source,
    (state_r == S_RM) |-> ($past(state_r) == S_SEARCH || $past(state_r) == S_MBEFW ||
                           $past(state_r) == S_MAFTW),
    "list unlink entered without a link read")
  `BPA_ASSERT(a_order_bound,
    (state_r == S_MBEF || state_r == S_FIN) |-> (o_r < 4'(ORDERS)),
    "merge walk order out of range")

endmodule
`default_nettype wire
